// ===== rtl/pidaw_pkg.sv =====
// ----------------------------------------------------------------------------
// pidaw_pkg - shared definitions for the PID controller with anti-windup
// Default widths, register and mode codes, and the command and status words
// passed between the step sequencer and the datapath.
// ----------------------------------------------------------------------------
package pidaw_pkg;

    // default sizes, Q16.16 data with a 48-bit integrator
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int ACC_WIDTH_DEF  = 48;

    // filter coefficient format: Q1.16, one is 65536
    localparam int          ALPHA_FRAC = 16;
    localparam logic [16:0] ALPHA_ONE  = 17'h10000;

    // default step time 0.01 s, given at 16 fraction bits
    localparam int DT_RESET_Q16 = 655;
    localparam int DT_REF_FRAC  = 16;

    // configuration register map
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP    = 3'd0,
        REG_KI_DT = 3'd1,
        REG_KD_DT = 3'd2,
        REG_ALPHA = 3'd3,
        REG_DT    = 3'd4,
        REG_LOW   = 3'd5,
        REG_HIGH  = 3'd6,
        REG_MODE  = 3'd7
    } reg_idx_t;

    // anti-windup modes (code three behaves as none)
    typedef enum logic [1:0] {
        MODE_NONE = 2'd0,
        MODE_COND = 2'd1,
        MODE_BACK = 2'd2
    } mode_t;

    // operand pair selected for the shared multiplier
    typedef enum logic [2:0] {
        MOP_ALPHA = 3'd0,
        MOP_KP    = 3'd1,
        MOP_KI    = 3'd2,
        MOP_KD    = 3'd3,
        MOP_BACK  = 3'd4
    } mop_t;

    // sequencer to datapath
    typedef struct packed {
        logic load_in;    // latch the input word
        logic clear;      // clear item: empty history, zero result
        logic do_err;     // form error and raw difference
        logic mul_en;     // multiplier digit step
        logic mul_first;  // upper digit, restarts the product
        mop_t mop;
        logic upd_filt;   // take filtered derivative, store measurement
        logic cap_pp;     // proportional term
        logic cap_cand;   // integrator candidate
        logic cap_s1;     // first partial sum
        logic cap_sum;    // full sum
        logic cap_cmd;    // clamp and conditional decision
        logic cap_bdiff;  // back-calculation error
        logic cap_back;   // back-calculation correction
        logic finish;     // commit integrator, load result word
    } dp_cmd_t;

    // datapath to sequencer
    typedef struct packed {
        logic back_calc;  // back-calculation active for this step
    } dp_sts_t;

endpackage

// ===== rtl/pidaw_cfg.sv =====
// ----------------------------------------------------------------------------
// pidaw_cfg - configuration register file
// Eight writable registers holding gains, filter coefficient, step time,
// output limits and the anti-windup mode. Always ready.
// ----------------------------------------------------------------------------
module pidaw_cfg #(
    parameter int DATA_WIDTH = pidaw_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = pidaw_pkg::FRAC_BITS_DEF,
    parameter int CFG_W      = (DATA_WIDTH > 17) ? DATA_WIDTH : 17
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pidaw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_W-1:0]                     cfg_data,
    output logic signed [DATA_WIDTH-1:0]         kp_gain,
    output logic signed [DATA_WIDTH-1:0]         ki_dt_gain,
    output logic signed [DATA_WIDTH-1:0]         kd_over_dt_gain,
    output logic [16:0]                          filter_alpha,
    output logic [DATA_WIDTH-2:0]                step_time,
    output logic signed [DATA_WIDTH-1:0]         out_low,
    output logic signed [DATA_WIDTH-1:0]         out_high,
    output logic [1:0]                           windup_mode
);

    localparam logic [DATA_WIDTH-1:0] ONE_Q     = DATA_WIDTH'(64'd1 << FRAC_BITS);
    localparam logic [DATA_WIDTH-1:0] NEG_ONE_Q = ~ONE_Q + DATA_WIDTH'(1);
    localparam logic [DATA_WIDTH-2:0] DT_RST    =
        (DATA_WIDTH-1)'((64'(pidaw_pkg::DT_RESET_Q16) << FRAC_BITS)
                        >> pidaw_pkg::DT_REF_FRAC);

    logic signed [DATA_WIDTH-1:0] kp_reg;
    logic signed [DATA_WIDTH-1:0] ki_reg;
    logic signed [DATA_WIDTH-1:0] kd_reg;
    logic [16:0]                  alpha_reg;
    logic [DATA_WIDTH-2:0]        dt_reg;
    logic signed [DATA_WIDTH-1:0] low_reg;
    logic signed [DATA_WIDTH-1:0] high_reg;
    logic [1:0]                   mode_reg;

    assign cfg_ready = 1'b1;

    // register writes, each truncated to its own width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg    <= ONE_Q;
            ki_reg    <= '0;
            kd_reg    <= '0;
            alpha_reg <= pidaw_pkg::ALPHA_ONE;
            dt_reg    <= DT_RST;
            low_reg   <= NEG_ONE_Q;
            high_reg  <= ONE_Q;
            mode_reg  <= pidaw_pkg::MODE_NONE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (pidaw_pkg::reg_idx_t'(cfg_index))
                pidaw_pkg::REG_KP:    kp_reg    <= cfg_data[DATA_WIDTH-1:0];
                pidaw_pkg::REG_KI_DT: ki_reg    <= cfg_data[DATA_WIDTH-1:0];
                pidaw_pkg::REG_KD_DT: kd_reg    <= cfg_data[DATA_WIDTH-1:0];
                pidaw_pkg::REG_ALPHA: alpha_reg <= cfg_data[16:0];
                pidaw_pkg::REG_DT:    dt_reg    <= cfg_data[DATA_WIDTH-2:0];
                pidaw_pkg::REG_LOW:   low_reg   <= cfg_data[DATA_WIDTH-1:0];
                pidaw_pkg::REG_HIGH:  high_reg  <= cfg_data[DATA_WIDTH-1:0];
                pidaw_pkg::REG_MODE:  mode_reg  <= cfg_data[1:0];
            endcase
        end
    end

    assign kp_gain         = kp_reg;
    assign ki_dt_gain      = ki_reg;
    assign kd_over_dt_gain = kd_reg;
    assign filter_alpha    = alpha_reg;
    assign step_time       = dt_reg;
    assign out_low         = low_reg;
    assign out_high        = high_reg;
    assign windup_mode     = mode_reg;

endmodule

// ===== rtl/pidaw_dp.sv =====
// ----------------------------------------------------------------------------
// pidaw_dp - PID datapath
// Controller state, one shared digit-serial multiplier (two digits per
// product), saturating adders, output clamp and the result word registers.
// ----------------------------------------------------------------------------
module pidaw_dp #(
    parameter int DATA_WIDTH = pidaw_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = pidaw_pkg::FRAC_BITS_DEF,
    parameter int ACC_WIDTH  = pidaw_pkg::ACC_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pidaw_pkg::dp_cmd_t            cmd,
    output pidaw_pkg::dp_sts_t            sts,
    input  logic signed [DATA_WIDTH-1:0]  setpoint,
    input  logic signed [DATA_WIDTH-1:0]  measurement,
    input  logic signed [DATA_WIDTH-1:0]  kp_gain,
    input  logic signed [DATA_WIDTH-1:0]  ki_dt_gain,
    input  logic signed [DATA_WIDTH-1:0]  kd_over_dt_gain,
    input  logic [16:0]                   filter_alpha,
    input  logic [DATA_WIDTH-2:0]         step_time,
    input  logic signed [DATA_WIDTH-1:0]  out_low,
    input  logic signed [DATA_WIDTH-1:0]  out_high,
    input  logic [1:0]                    windup_mode,
    output logic signed [DATA_WIDTH-1:0]  command,
    output logic signed [DATA_WIDTH-1:0]  unsaturated,
    output logic signed [DATA_WIDTH-1:0]  integral_term,
    output logic                          saturated
);

    localparam int D   = DATA_WIDTH;
    localparam int A   = ACC_WIDTH;
    localparam int DAM = (D > A) ? D : A;
    // first partial sum and back-calculation error are held to 64 bits at most
    localparam int S1W = (A + 1 > 64) ? 64 : A + 1;
    localparam int AW  = (DAM + 1 > 64) ? 64 : DAM + 1;
    localparam int BW  = (D + 1 > 18) ? D + 1 : 18;
    localparam int DIG = (BW + 1) / 2;
    localparam int PW  = AW + 2 * DIG;
    localparam int XW  = PW + 2;

    localparam logic signed [XW-1:0] ONE_X = {{(XW-1){1'b0}}, 1'b1};

    // saturate a wide signed value to w bits (result still XW wide)
    function automatic logic signed [XW-1:0] sat_w(input logic signed [XW-1:0] x,
                                                  input int unsigned w);
        logic signed [XW-1:0] hi;
        logic signed [XW-1:0] lo;
        hi = (ONE_X <<< (w - 1)) - ONE_X;
        lo = ~hi;
        if (x > hi)
            sat_w = hi;
        else if (x < lo)
            sat_w = lo;
        else
            sat_w = x;
    endfunction

    // controller state
    logic signed [A-1:0]   acc_reg;
    logic signed [D-1:0]   filt_reg;
    logic signed [D-1:0]   prev_reg;
    logic                  have_prev_reg;

    // working registers
    logic signed [D-1:0]   sp_reg;
    logic signed [D-1:0]   meas_reg;
    logic signed [D-1:0]   err_reg;
    logic signed [D:0]     diff_reg;
    logic signed [PW-1:0]  mul_acc_reg;
    logic signed [A-1:0]   pp_reg;
    logic signed [A-1:0]   cand_reg;
    logic signed [S1W-1:0] s1_reg;
    logic signed [A-1:0]   sum_reg;
    logic signed [D-1:0]   cmd_reg;
    logic                  take_reg;
    logic signed [AW-1:0]  bdiff_reg;

    // result word
    logic signed [D-1:0]   command_reg;
    logic signed [D-1:0]   unsat_reg;
    logic signed [D-1:0]   integ_reg;
    logic                  saturated_reg;

    logic signed [D-1:0]     err_next;
    logic signed [D-1:0]     raw_diff;
    logic signed [D:0]       diff_next;
    logic signed [D-1:0]     filt_next;
    logic signed [D:0]       neg_filt;
    logic [16:0]             alpha_eff;
    logic signed [AW-1:0]    mul_a;
    logic signed [2*DIG-1:0] mul_b;
    logic signed [DIG:0]     digit;
    logic signed [AW+DIG:0]  part;
    logic signed [PW-1:0]    mul_acc_next;
    logic signed [A-1:0]     prod_sat;
    logic signed [A-1:0]     cand_next;
    logic signed [S1W-1:0]   s1_next;
    logic signed [A-1:0]     sum_next;
    logic signed [XW-1:0]    sum_x;
    logic signed [XW-1:0]    lo_x;
    logic signed [XW-1:0]    hi_x;
    logic signed [XW-1:0]    floor_x;
    logic signed [XW-1:0]    cmd_x;
    logic signed [D-1:0]     cmd_next;
    logic                    take_next;
    logic                    err_neg;
    logic                    err_pos;
    logic signed [AW-1:0]    bdiff_next;
    logic signed [A-1:0]     back_next;
    logic signed [A-1:0]     acc_next;

    // error and raw measurement difference
    assign err_next  = D'(sat_w(XW'(sp_reg) - XW'(meas_reg), D));
    assign raw_diff  = have_prev_reg ? D'(sat_w(XW'(meas_reg) - XW'(prev_reg), D)) : '0;
    assign diff_next = (D+1)'(raw_diff) - (D+1)'(filt_reg);
    assign neg_filt  = -((D+1)'(filt_reg));
    assign alpha_eff = (filter_alpha > pidaw_pkg::ALPHA_ONE) ? pidaw_pkg::ALPHA_ONE
                                                              : filter_alpha;

    // multiplier operand select
    always_comb
    begin
        unique case (cmd.mop)
            pidaw_pkg::MOP_ALPHA:
            begin
                mul_a = AW'(diff_reg);
                mul_b = (2*DIG)'($signed({1'b0, alpha_eff}));
            end
            pidaw_pkg::MOP_KP:
            begin
                mul_a = AW'(err_reg);
                mul_b = (2*DIG)'(kp_gain);
            end
            pidaw_pkg::MOP_KI:
            begin
                mul_a = AW'(err_reg);
                mul_b = (2*DIG)'(ki_dt_gain);
            end
            pidaw_pkg::MOP_KD:
            begin
                mul_a = AW'(neg_filt);
                mul_b = (2*DIG)'(kd_over_dt_gain);
            end
            pidaw_pkg::MOP_BACK:
            begin
                mul_a = bdiff_reg;
                mul_b = (2*DIG)'($signed({1'b0, step_time}));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // digit step: upper digit signed first, then lower digit unsigned
    assign digit = cmd.mul_first ? (DIG+1)'($signed(mul_b[2*DIG-1:DIG]))
                                 : $signed({1'b0, mul_b[DIG-1:0]});
    assign part  = mul_a * digit;
    assign mul_acc_next = cmd.mul_first ? PW'(part)
                                        : (mul_acc_reg <<< DIG) + PW'(part);

    // product rounded toward minus infinity, saturated to accumulator width
    assign prod_sat  = A'(sat_w(XW'(mul_acc_reg) >>> FRAC_BITS, A));
    assign filt_next = D'(sat_w(XW'(filt_reg)
                                + (XW'(mul_acc_reg) >>> pidaw_pkg::ALPHA_FRAC), D));
    assign cand_next = A'(sat_w(XW'(acc_reg) + XW'(prod_sat), A));
    assign s1_next   = S1W'(sat_w(XW'(pp_reg) + XW'(cand_reg), S1W));
    assign sum_next  = A'(sat_w(XW'(s1_reg) + XW'(prod_sat), A));
    assign back_next = A'(sat_w(XW'(cand_reg) + XW'(prod_sat), A));

    // clamp; the upper limit wins when the limits cross
    assign sum_x     = XW'(sum_reg);
    assign lo_x      = XW'(out_low);
    assign hi_x      = XW'(out_high);
    assign floor_x   = (sum_x < lo_x) ? lo_x : sum_x;
    assign cmd_x     = (floor_x > hi_x) ? hi_x : floor_x;
    assign cmd_next  = D'(cmd_x);
    assign err_neg   = err_reg[D-1];
    assign err_pos   = !err_reg[D-1] && (err_reg != '0);
    assign take_next = (cmd_x == sum_x) || ((sum_x > hi_x) && err_neg)
                       || ((sum_x < lo_x) && err_pos);
    assign bdiff_next = AW'(sat_w(XW'(cmd_reg) - XW'(sum_reg), AW));

    // integrator commit
    assign acc_next = ((windup_mode == pidaw_pkg::MODE_COND) && !take_reg) ? acc_reg
                                                                           : cand_reg;

    assign sts.back_calc = (windup_mode == pidaw_pkg::MODE_BACK)
                           && !ki_dt_gain[D-1] && (ki_dt_gain != '0);

    // controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            filt_reg      <= '0;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
        end
        else if (cmd.clear)
        begin
            acc_reg       <= '0;
            filt_reg      <= '0;
            have_prev_reg <= 1'b0;
        end
        else
        begin
            if (cmd.upd_filt)
            begin
                filt_reg      <= filt_next;
                prev_reg      <= meas_reg;
                have_prev_reg <= 1'b1;
            end
            if (cmd.finish)
                acc_reg <= acc_next;
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            sp_reg   <= setpoint;
            meas_reg <= measurement;
        end
        if (cmd.do_err)
        begin
            err_reg  <= err_next;
            diff_reg <= diff_next;
        end
        if (cmd.mul_en)
            mul_acc_reg <= mul_acc_next;
        if (cmd.cap_pp)
            pp_reg <= prod_sat;
        if (cmd.cap_cand)
            cand_reg <= cand_next;
        else if (cmd.cap_back)
            cand_reg <= back_next;
        if (cmd.cap_s1)
            s1_reg <= s1_next;
        if (cmd.cap_sum)
            sum_reg <= sum_next;
        if (cmd.cap_cmd)
        begin
            cmd_reg  <= cmd_next;
            take_reg <= take_next;
        end
        if (cmd.cap_bdiff)
            bdiff_reg <= bdiff_next;
        if (cmd.clear)
        begin
            command_reg   <= '0;
            unsat_reg     <= '0;
            integ_reg     <= '0;
            saturated_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            command_reg   <= cmd_reg;
            unsat_reg     <= D'(sat_w(XW'(sum_reg), D));
            integ_reg     <= D'(sat_w(XW'(acc_next), D));
            saturated_reg <= (XW'(cmd_reg) != XW'(sum_reg));
        end
    end

    assign command       = command_reg;
    assign unsaturated   = unsat_reg;
    assign integral_term = integ_reg;
    assign saturated     = saturated_reg;

endmodule

// ===== rtl/pidaw_ctrl.sv =====
// ----------------------------------------------------------------------------
// pidaw_ctrl - step sequencer
// Walks one clear word or one control step through the datapath: error,
// filter product, the three gain products, sums, clamp and optional
// back-calculation; owns the handshakes of both word channels.
// ----------------------------------------------------------------------------
module pidaw_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                kind,
    output logic                out_valid,
    input  logic                out_ready,
    output pidaw_pkg::dp_cmd_t  cmd,
    input  pidaw_pkg::dp_sts_t  sts
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_ERR,
        ST_A0,
        ST_A1,
        ST_P0,
        ST_P1,
        ST_I0,
        ST_I1,
        ST_D0,
        ST_D1,
        ST_SUM,
        ST_CLAMP,
        ST_BD,
        ST_B0,
        ST_B1,
        ST_BACC,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // next state and output valid
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = kind ? ST_CLEAR : ST_ERR;
            end
            ST_CLEAR:
            begin
                if (out_free)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            ST_ERR:   state_next = ST_A0;
            ST_A0:    state_next = ST_A1;
            ST_A1:    state_next = ST_P0;
            ST_P0:    state_next = ST_P1;
            ST_P1:    state_next = ST_I0;
            ST_I0:    state_next = ST_I1;
            ST_I1:    state_next = ST_D0;
            ST_D0:    state_next = ST_D1;
            ST_D1:    state_next = ST_SUM;
            ST_SUM:   state_next = ST_CLAMP;
            ST_CLAMP: state_next = sts.back_calc ? ST_BD : ST_DONE;
            ST_BD:    state_next = ST_B0;
            ST_B0:    state_next = ST_B1;
            ST_B1:    state_next = ST_BACC;
            ST_BACC:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath commands
    always_comb
    begin
        cmd           = '0;
        cmd.mop       = pidaw_pkg::MOP_ALPHA;
        cmd.load_in   = in_valid && (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_CLEAR: cmd.clear = out_free;
            ST_ERR:   cmd.do_err = 1'b1;
            ST_A0:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_first = 1'b1;
            end
            ST_A1:    cmd.mul_en = 1'b1;
            ST_P0:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_first = 1'b1;
                cmd.mop       = pidaw_pkg::MOP_KP;
                cmd.upd_filt  = 1'b1;
            end
            ST_P1:
            begin
                cmd.mul_en = 1'b1;
                cmd.mop    = pidaw_pkg::MOP_KP;
            end
            ST_I0:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_first = 1'b1;
                cmd.mop       = pidaw_pkg::MOP_KI;
                cmd.cap_pp    = 1'b1;
            end
            ST_I1:
            begin
                cmd.mul_en = 1'b1;
                cmd.mop    = pidaw_pkg::MOP_KI;
            end
            ST_D0:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_first = 1'b1;
                cmd.mop       = pidaw_pkg::MOP_KD;
                cmd.cap_cand  = 1'b1;
            end
            ST_D1:
            begin
                cmd.mul_en = 1'b1;
                cmd.mop    = pidaw_pkg::MOP_KD;
                cmd.cap_s1 = 1'b1;
            end
            ST_SUM:   cmd.cap_sum = 1'b1;
            ST_CLAMP: cmd.cap_cmd = 1'b1;
            ST_BD:    cmd.cap_bdiff = 1'b1;
            ST_B0:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_first = 1'b1;
                cmd.mop       = pidaw_pkg::MOP_BACK;
            end
            ST_B1:
            begin
                cmd.mul_en = 1'b1;
                cmd.mop    = pidaw_pkg::MOP_BACK;
            end
            ST_BACC:  cmd.cap_back = 1'b1;
            ST_DONE:  cmd.finish = out_free;
            default:  cmd.clear = 1'b0;
        endcase
    end

`ifndef SYNTHESIS
    // a result is never written over one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish || cmd.clear) |-> (!out_valid_reg || out_ready))
        else $error("result loaded while output word pending");

    // one step at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while a step is in progress");

    // every product gets its lower digit, same operands
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_first |=> (cmd.mul_en && !cmd.mul_first && (cmd.mop == $past(cmd.mop))))
        else $error("multiplier digit sequence broken");

    // output valid rises only when a result is loaded
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.finish || cmd.clear))
        else $error("output valid without a result");
`endif

endmodule

// ===== rtl/pid_controller_antiwindup.sv =====
// ----------------------------------------------------------------------------
// pid_controller_antiwindup - fixed-point PID step with anti-windup
// Derivative on measurement through a first-order filter, clamped output,
// integrator modes: always, conditional, back-calculation.
// ----------------------------------------------------------------------------
// Use:
//   Input channel (in_valid/in_ready) takes one word: kind 0 is a control step
//   on setpoint and measurement, kind 1 clears integrator and derivative
//   history. Each word gives exactly one result word on out_valid/out_ready:
//   command, unsaturated sum, integral term and the saturated flag.
//   Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready
//   and should only be written while no step is in progress.
// Step sequence:
//   A control step forms the error, then the filter, proportional, integral
//   and derivative products, the sum and the clamp; with back-calculation
//   active it adds the back-calculation error and product before the commit.
//   The single shared multiplier forms each of the four or five products in
//   two digit steps. A new word is accepted only once the last has committed.
// Reset and stall:
//   Reset loads the default registers, empties the controller state and drops
//   out_valid. A waiting result holds the output register; the next word may
//   be accepted meanwhile, and its step waits at its last cycle until the
//   output is taken.
// ----------------------------------------------------------------------------
module pid_controller_antiwindup #(
    parameter int DATA_WIDTH = pidaw_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = pidaw_pkg::FRAC_BITS_DEF,
    parameter int ACC_WIDTH  = pidaw_pkg::ACC_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pidaw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [((DATA_WIDTH > 17) ? DATA_WIDTH : 17)-1:0] cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              kind,
    input  logic signed [DATA_WIDTH-1:0]      setpoint,
    input  logic signed [DATA_WIDTH-1:0]      measurement,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [DATA_WIDTH-1:0]      command,
    output logic signed [DATA_WIDTH-1:0]      unsaturated,
    output logic signed [DATA_WIDTH-1:0]      integral_term,
    output logic                              saturated
);

    localparam int CFG_W = (DATA_WIDTH > 17) ? DATA_WIDTH : 17;

    logic signed [DATA_WIDTH-1:0] kp_gain;
    logic signed [DATA_WIDTH-1:0] ki_dt_gain;
    logic signed [DATA_WIDTH-1:0] kd_over_dt_gain;
    logic [16:0]                  filter_alpha;
    logic [DATA_WIDTH-2:0]        step_time;
    logic signed [DATA_WIDTH-1:0] out_low;
    logic signed [DATA_WIDTH-1:0] out_high;
    logic [1:0]                   windup_mode;

    pidaw_pkg::dp_cmd_t dp_cmd;
    pidaw_pkg::dp_sts_t dp_sts;

    // configuration registers
    pidaw_cfg #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .CFG_W      (CFG_W)
    ) u_cfg (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .kp_gain         (kp_gain),
        .ki_dt_gain      (ki_dt_gain),
        .kd_over_dt_gain (kd_over_dt_gain),
        .filter_alpha    (filter_alpha),
        .step_time       (step_time),
        .out_low         (out_low),
        .out_high        (out_high),
        .windup_mode     (windup_mode)
    );

    // step sequencer
    pidaw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (dp_cmd),
        .sts       (dp_sts)
    );

    // datapath
    pidaw_dp #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .ACC_WIDTH  (ACC_WIDTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (dp_cmd),
        .sts             (dp_sts),
        .setpoint        (setpoint),
        .measurement     (measurement),
        .kp_gain         (kp_gain),
        .ki_dt_gain      (ki_dt_gain),
        .kd_over_dt_gain (kd_over_dt_gain),
        .filter_alpha    (filter_alpha),
        .step_time       (step_time),
        .out_low         (out_low),
        .out_high        (out_high),
        .windup_mode     (windup_mode),
        .command         (command),
        .unsaturated     (unsaturated),
        .integral_term   (integral_term),
        .saturated       (saturated)
    );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - testbench for pid_controller_antiwindup
// Streams step and clear words through the controller under several register
// settings, with random idling on both handshakes. A behavioural PID model
// kept in step with every accepted word predicts each result word, which is
// compared field by field as it leaves the block.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int DW     = pidaw_pkg::DATA_WIDTH_DEF;
    localparam int FB     = pidaw_pkg::FRAC_BITS_DEF;
    localparam int AW     = pidaw_pkg::ACC_WIDTH_DEF;
    localparam int CFG_DW = (DW > 17) ? DW : 17;

    localparam int                   Q_ONE = 1 << FB;
    localparam logic signed [DW-1:0] D_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] D_MIN = {1'b1, {(DW-1){1'b0}}};

    localparam logic       KIND_STEP  = 1'b0;
    localparam logic       KIND_CLEAR = 1'b1;
    // unused mode code, the block treats it as plain integration
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam int IDLE_PAD    = 20;

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic signed [DW-1:0] command;
        logic signed [DW-1:0] unsaturated;
        logic signed [DW-1:0] integral_term;
        logic                 saturated;
    } pid_out_t;

    // ports
    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [pidaw_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DW-1:0]               cfg_data = '0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic                            kind = 1'b0;
    logic signed [DW-1:0]            setpoint = '0;
    logic signed [DW-1:0]            measurement = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic signed [DW-1:0]            command;
    logic signed [DW-1:0]            unsaturated;
    logic signed [DW-1:0]            integral_term;
    logic                            saturated;

    // register copies, reset values
    logic signed [DW-1:0]    kp_q   = Q_ONE;
    logic signed [DW-1:0]    kidt_q = '0;
    logic signed [DW-1:0]    kddt_q = '0;
    logic [16:0]             alpha_q = pidaw_pkg::ALPHA_ONE;
    logic [DW-2:0]           dt_q   = (DW-1)'(pidaw_pkg::DT_RESET_Q16);
    logic signed [DW-1:0]    low_q  = -Q_ONE;
    logic signed [DW-1:0]    high_q = Q_ONE;
    logic [1:0]              mode_q = pidaw_pkg::MODE_NONE;

    // controller state copies
    logic signed [AW-1:0]    acc_q = '0;
    logic signed [DW-1:0]    filt_q = '0;
    logic signed [DW-1:0]    prev_meas_q = '0;
    logic                    have_prev_q = 1'b0;

    pid_out_t                outputs_due[$];
    int                      fail_count = 0;
    bit                      tx_eager = 1'b0;
    bit                      rx_eager = 1'b0;
    int                      rx_hold = 0;

    pid_controller_antiwindup DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .setpoint      (setpoint),
        .measurement   (measurement),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .command       (command),
        .unsaturated   (unsaturated),
        .integral_term (integral_term),
        .saturated     (saturated)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // fixed-point helpers, exact in 128 bits
    // ------------------------------------------------------------------
    function automatic wide_t sat_to(input wide_t x, input int w);
        wide_t top, bottom;
        top    = (wide_t'(1) <<< (w - 1)) - wide_t'(1);
        bottom = -top - wide_t'(1);
        if (x > top)
            return top;
        if (x < bottom)
            return bottom;
        return x;
    endfunction

    // product, floor shift, saturate
    function automatic wide_t qmul(input wide_t a, input wide_t b, input int shift,
                                   input int w);
        return sat_to((a * b) >>> shift, w);
    endfunction

    // ------------------------------------------------------------------
    // one controller step on the state copies
    // ------------------------------------------------------------------
    function automatic pid_out_t pid_next_output(input logic k,
                                                 input logic signed [DW-1:0] sp_in,
                                                 input logic signed [DW-1:0] ms_in);
        pid_out_t r;
        wide_t sp, ms, pm, err, raw, a, filt, acc, cand, sum, cmd, lo, hi;
        wide_t kp, kidt, kddt, dt, u, it;
        r = '0;
        if (k == KIND_CLEAR)
        begin
            // history emptied, last measurement kept
            acc_q       = '0;
            filt_q      = '0;
            have_prev_q = 1'b0;
            return r;
        end
        sp   = sp_in;
        ms   = ms_in;
        pm   = prev_meas_q;
        filt = filt_q;
        acc  = acc_q;
        kp   = kp_q;
        kidt = kidt_q;
        kddt = kddt_q;
        dt   = dt_q;
        lo   = low_q;
        hi   = high_q;
        a    = (alpha_q > pidaw_pkg::ALPHA_ONE) ? pidaw_pkg::ALPHA_ONE : alpha_q;

        // error and filtered derivative on measurement
        err  = sat_to(sp - ms, DW);
        raw  = have_prev_q ? sat_to(ms - pm, DW) : wide_t'(0);
        filt = sat_to(filt + qmul(a, raw - filt, pidaw_pkg::ALPHA_FRAC, DW + 1), DW);
        filt_q      = filt[DW-1:0];
        prev_meas_q = ms_in;
        have_prev_q = 1'b1;

        // terms, sum and clamp (high limit wins when crossed)
        cand = sat_to(acc + qmul(kidt, err, FB, AW), AW);
        sum  = sat_to(qmul(kp, err, FB, AW) + cand + qmul(kddt, -filt, FB, AW), AW);
        cmd  = (sum < lo) ? lo : sum;
        if (cmd > hi)
            cmd = hi;

        // integrator update per anti-windup mode
        case (mode_q)
            pidaw_pkg::MODE_COND:
            begin
                if (cmd == sum || (sum > hi && err < 0) || (sum < lo && err > 0))
                    acc = cand;
            end
            pidaw_pkg::MODE_BACK:
            begin
                if (kidt > 0)
                    cand = sat_to(cand + qmul(cmd - sum, dt, FB, AW), AW);
                acc = cand;
            end
            default:
                acc = cand;
        endcase
        acc_q = acc[AW-1:0];

        u  = sat_to(sum, DW);
        it = sat_to(acc, DW);
        r.command       = cmd[DW-1:0];
        r.unsaturated   = u[DW-1:0];
        r.integral_term = it[DW-1:0];
        r.saturated     = (cmd != sum);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // random helpers
    // ------------------------------------------------------------------
    // mostly short gaps, a few long
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // process value: small levels mostly, some anywhere, some at the rails
    function automatic logic signed [DW-1:0] rand_level();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 3)
            return $urandom;
        if (pick == 3)
            return ($urandom_range(0, 1) != 0) ? D_MAX : D_MIN;
        return $signed($urandom_range(0, 16 * Q_ONE)) - 8 * Q_ONE;
    endfunction

    // gain within +/- lim, with the odd full-range or extreme value
    function automatic logic signed [DW-1:0] rand_gain(input int lim);
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick < 2)
            return $urandom;
        if (pick == 2)
            return ($urandom_range(0, 1) != 0) ? D_MAX : D_MIN;
        if (pick == 3)
            return '0;
        return $signed($urandom_range(0, 2 * lim)) - lim;
    endfunction

    // ------------------------------------------------------------------
    // result checking at the rising edge
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [DW-1:0] want,
                                        input logic [DW-1:0] got);
        if (got !== want)
        begin
            fail_count++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, $signed(want), $signed(got));
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        pid_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (outputs_due.size() == 0)
            begin
                fail_count++;
                $display({"%0t ns: result word with none outstanding, ",
                          "expected none, actual command %0d"}, $time, command);
            end
            else
            begin
                want = outputs_due.pop_front();
                check_field("command", want.command, command);
                check_field("unsaturated", want.unsaturated, unsaturated);
                check_field("integral_term", want.integral_term, integral_term);
                check_field("saturated", {{(DW-1){1'b0}}, want.saturated},
                            {{(DW-1){1'b0}}, saturated});
            end
        end
    end

    // result side back-pressure
    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            out_ready = 1'b0;
            rx_hold   = rx_hold - 1;
        end
        else if (!rx_eager && $urandom_range(0, 3) == 0)
        begin
            out_ready = 1'b0;
            rx_hold   = pick_gap();
        end
        else
            out_ready = 1'b1;
    end

    // ------------------------------------------------------------------
    // drivers, entered and left at a falling edge
    // ------------------------------------------------------------------
    task automatic write_reg(input pidaw_pkg::reg_idx_t idx,
                             input logic [CFG_DW-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            pidaw_pkg::REG_KP:    kp_q    = data[DW-1:0];
            pidaw_pkg::REG_KI_DT: kidt_q  = data[DW-1:0];
            pidaw_pkg::REG_KD_DT: kddt_q  = data[DW-1:0];
            pidaw_pkg::REG_ALPHA: alpha_q = data[16:0];
            pidaw_pkg::REG_DT:    dt_q    = data[DW-2:0];
            pidaw_pkg::REG_LOW:   low_q   = data[DW-1:0];
            pidaw_pkg::REG_HIGH:  high_q  = data[DW-1:0];
            default:              mode_q  = data[1:0];
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_all(input logic signed [DW-1:0] kp, input logic signed [DW-1:0] kidt,
                           input logic signed [DW-1:0] kddt, input logic [CFG_DW-1:0] alpha,
                           input logic [CFG_DW-1:0] dt, input logic signed [DW-1:0] lo,
                           input logic signed [DW-1:0] hi, input logic [1:0] mode);
        write_reg(pidaw_pkg::REG_KP, kp);
        write_reg(pidaw_pkg::REG_KI_DT, kidt);
        write_reg(pidaw_pkg::REG_KD_DT, kddt);
        write_reg(pidaw_pkg::REG_ALPHA, alpha);
        write_reg(pidaw_pkg::REG_DT, dt);
        write_reg(pidaw_pkg::REG_LOW, lo);
        write_reg(pidaw_pkg::REG_HIGH, hi);
        write_reg(pidaw_pkg::REG_MODE, CFG_DW'(mode));
    endtask

    // valid is left high on return; the caller sends again or drains at once
    task automatic send_word(input logic k, input logic signed [DW-1:0] sp,
                             input logic signed [DW-1:0] ms);
        int gap;
        gap = tx_eager ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    = 1'b1;
        kind        = k;
        setpoint    = sp;
        measurement = ms;
        do
            @(posedge clk);
        while (!in_ready);
        outputs_due.push_back(pid_next_output(k, sp, ms));
        @(negedge clk);
    endtask

    // stop sending, let every result out, then allow the block to settle
    task automatic wait_idle();
        in_valid = 1'b0;
        while (outputs_due.size() != 0)
            @(negedge clk);
        repeat (IDLE_PAD) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // reset settings: first sample, rail inputs, clamp both ways, clear
    task automatic test_defaults();
        send_word(KIND_STEP, 0, 0);
        send_word(KIND_STEP, D_MAX, D_MIN);
        send_word(KIND_STEP, D_MIN, D_MAX);
        send_word(KIND_STEP, Q_ONE / 2, 0);
        send_word(KIND_CLEAR, D_MAX, D_MIN);
        send_word(KIND_STEP, 0, -1);
        wait_idle();
    endtask

    // wind the integrator up, then each branch of the conditional rule
    task automatic test_conditional_integration();
        set_all(0, Q_ONE, 0, pidaw_pkg::ALPHA_ONE, pidaw_pkg::DT_RESET_Q16, -Q_ONE, Q_ONE,
                pidaw_pkg::MODE_NONE);
        send_word(KIND_STEP, 3 * Q_ONE / 2, 0);
        send_word(KIND_STEP, 3 * Q_ONE / 2, 0);
        wait_idle();
        write_reg(pidaw_pkg::REG_KP, -4 * Q_ONE);
        write_reg(pidaw_pkg::REG_MODE, CFG_DW'(pidaw_pkg::MODE_COND));
        // above high, error negative: integrate
        send_word(KIND_STEP, -Q_ONE / 4, 0);
        // above high, error positive: hold
        send_word(KIND_STEP, Q_ONE / 2, 0);
        send_word(KIND_CLEAR, 0, 0);
        // below low, error positive: integrate
        send_word(KIND_STEP, Q_ONE / 2, 0);
        send_word(KIND_STEP, -Q_ONE, 0);
        send_word(KIND_STEP, -Q_ONE / 16, 0);
        send_word(KIND_STEP, Q_ONE, 0);
        wait_idle();
    endtask

    // crossed limits and full step time; then ki_dt negative and positive
    task automatic test_back_calculation();
        set_all(2 * Q_ONE, Q_ONE / 2, 0, pidaw_pkg::ALPHA_ONE, '1, Q_ONE, -Q_ONE,
                pidaw_pkg::MODE_BACK);
        send_word(KIND_STEP, Q_ONE, 0);
        send_word(KIND_STEP, -2 * Q_ONE, 0);
        wait_idle();
        write_reg(pidaw_pkg::REG_KI_DT, -Q_ONE / 2);
        write_reg(pidaw_pkg::REG_DT, Q_ONE / 10);
        write_reg(pidaw_pkg::REG_LOW, -Q_ONE);
        write_reg(pidaw_pkg::REG_HIGH, Q_ONE);
        send_word(KIND_STEP, 3 * Q_ONE, 0);
        wait_idle();
        write_reg(pidaw_pkg::REG_KI_DT, Q_ONE / 4);
        send_word(KIND_STEP, 3 * Q_ONE, 0);
        send_word(KIND_STEP, 3 * Q_ONE, 0);
        wait_idle();
    endtask

    // alpha above one, alpha zero, the unused mode code, rail measurements
    task automatic test_filter_and_spare_mode();
        set_all(Q_ONE, Q_ONE / 4, -3 * Q_ONE, '1, pidaw_pkg::DT_RESET_Q16, D_MIN, D_MAX,
                MODE_SPARE);
        send_word(KIND_STEP, 0, 0);
        send_word(KIND_STEP, 0, 1000 * Q_ONE);
        send_word(KIND_STEP, 0, D_MIN);
        send_word(KIND_STEP, 0, D_MAX);
        wait_idle();
        write_reg(pidaw_pkg::REG_ALPHA, '0);
        send_word(KIND_STEP, 0, 0);
        send_word(KIND_STEP, Q_ONE, -Q_ONE);
        wait_idle();
    endtask

    // settings for one random phase; the first three are fixed corners
    task automatic configure_random(input int phase);
        logic [CFG_DW-1:0]    junk;
        logic [16:0]          alpha;
        logic [CFG_DW-1:0]    dt;
        logic signed [DW-1:0] lo, hi, swap;
        junk  = $urandom;
        alpha = ($urandom_range(0, 3) == 0) ? pidaw_pkg::ALPHA_ONE
                                            : 17'($urandom_range(0, 131071));
        dt    = ($urandom_range(0, 4) == 0) ? CFG_DW'($urandom)
                                            : CFG_DW'($urandom_range(0, Q_ONE));
        lo    = rand_gain(4 * Q_ONE);
        hi    = rand_gain(4 * Q_ONE);
        // ordered limits mostly, crossed now and then
        if ((lo > hi) != ($urandom_range(0, 6) == 0))
        begin
            swap = lo;
            lo   = hi;
            hi   = swap;
        end
        case (phase)
            0: set_all(D_MAX, D_MAX, D_MAX, {junk[CFG_DW-1:17], pidaw_pkg::ALPHA_ONE}, '1,
                       D_MIN, D_MAX, pidaw_pkg::MODE_NONE);
            1: set_all(D_MIN, D_MIN, D_MIN, {junk[CFG_DW-1:17], 17'd0}, '0,
                       '0, '0, pidaw_pkg::MODE_BACK);
            2: set_all(2 * Q_ONE, Q_ONE / 4, Q_ONE / 2, 17'h02000, pidaw_pkg::DT_RESET_Q16,
                       -2 * Q_ONE, 2 * Q_ONE, pidaw_pkg::MODE_COND);
            default: set_all(rand_gain(4 * Q_ONE), rand_gain(Q_ONE / 2), rand_gain(2 * Q_ONE),
                             {junk[CFG_DW-1:17], alpha}, dt, lo, hi,
                             2'($urandom_range(0, 3)));
        endcase
    endtask

    // random phases: tracking sequences with the odd jump and clear
    task automatic test_random_phases();
        logic signed [DW-1:0] sp, ms;
        int unsigned          pick;
        for (int phase = 0; phase < 12; phase++)
        begin
            configure_random(phase);
            tx_eager = ($urandom_range(0, 3) == 0);
            rx_eager = ($urandom_range(0, 3) == 0);
            sp = rand_level();
            ms = sp + ($signed($urandom_range(0, 4 * Q_ONE)) - 2 * Q_ONE);
            for (int n = 0; n < 50; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 4)
                    send_word(KIND_CLEAR, $urandom, $urandom);
                else
                begin
                    if (pick < 12)
                        sp = rand_level();
                    if (pick < 90)
                        ms = ms + ($signed($urandom_range(0, 2 * Q_ONE)) - Q_ONE);
                    else
                        ms = rand_level();
                    send_word(KIND_STEP, sp, ms);
                end
                // hold off until the block has emptied, mid-phase
                if (phase == 5 && n == 25)
                    wait_idle();
            end
            wait_idle();
        end
        tx_eager = 1'b0;
        rx_eager = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_defaults();
        test_conditional_integration();
        test_back_calculation();
        test_filter_and_spare_mode();
        test_random_phases();
        wait_idle();

        if (fail_count == 0)
            $display("** pid_controller_antiwindup: PASSED **");
        else
            $display("** pid_controller_antiwindup: FAILED **");
        $finish;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("** pid_controller_antiwindup: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/pidaw_pkg.sv
rtl/pidaw_cfg.sv
rtl/pidaw_dp.sv
rtl/pidaw_ctrl.sv
rtl/pid_controller_antiwindup.sv
test/tb_top.sv
